@@ design/ufph_pkg.sv @@
`timescale 1ns / 1ps

package ufph_pkg;

	localparam int NUM_ELEMENTS = 1024;
	localparam int ELEM_W = 10;
	localparam int IDX_W = (NUM_ELEMENTS > 2) ? $clog2(NUM_ELEMENTS) : 1;
	localparam int NODE_W = (IDX_W > ELEM_W) ? IDX_W : ELEM_W;

	typedef enum logic {
		OP_FIND  = 1'b0,
		OP_UNITE = 1'b1
	} uf_op_t;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic  go;
		logic  link;
		node_t node;
		node_t link_addr;
		node_t link_data;
	} walk_cmd_t;

	typedef struct packed {
		logic  ready;
		logic  done;
		node_t root;
	} walk_sts_t;

	function automatic logic in_range(input node_t n);
		return 32'(n) < 32'(NUM_ELEMENTS);
	endfunction

endpackage

@@ design/ufph_walker.sv @@
`timescale 1ns / 1ps

module ufph_walker
	import ufph_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  walk_cmd_t cmd,
	output walk_sts_t sts
);

	typedef enum logic [1:0] {
		W_CLEAR,
		W_IDLE,
		W_UP,
		W_GRAND
	} wstate_t;

	wstate_t state_q;
	idx_t    clr_q;
	node_t   node_q;
	node_t   root_q;
	logic    done_q;

	idx_t    mem [NUM_ELEMENTS];
	idx_t    rdata_q;
	idx_t    raddr;
	idx_t    waddr;
	idx_t    wdata;
	logic    we;
	node_t   up;

	assign up = NODE_W'(rdata_q);

	always_comb begin
		raddr = node_q[IDX_W-1:0];
		waddr = node_q[IDX_W-1:0];
		wdata = rdata_q;
		we    = 1'b0;
		unique case (state_q)
			W_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = clr_q;
			end
			W_IDLE: begin
				raddr = cmd.node[IDX_W-1:0];
				if (cmd.go && cmd.link && in_range(cmd.link_addr) && in_range(cmd.link_data)) begin
					we    = 1'b1;
					waddr = cmd.link_addr[IDX_W-1:0];
					wdata = cmd.link_data[IDX_W-1:0];
				end
			end
			W_UP: begin
				raddr = rdata_q;
			end
			W_GRAND: begin
				we    = 1'b1;
				waddr = node_q[IDX_W-1:0];
				wdata = rdata_q;
				raddr = rdata_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_CLEAR;
			clr_q   <= '0;
			node_q  <= '0;
			root_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				W_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(NUM_ELEMENTS - 1)) begin
						state_q <= W_IDLE;
					end
				end
				W_IDLE: begin
					if (cmd.go && !cmd.link) begin
						node_q <= cmd.node;
						if (in_range(cmd.node)) begin
							state_q <= W_UP;
						end else begin
							done_q <= 1'b1;
							root_q <= cmd.node;
						end
					end
				end
				W_UP: begin
					if (up == node_q) begin
						done_q  <= 1'b1;
						root_q  <= node_q;
						state_q <= W_IDLE;
					end else begin
						state_q <= W_GRAND;
					end
				end
				W_GRAND: begin
					// halve: entry now points at grandparent, walk moves there
					node_q  <= up;
					state_q <= W_UP;
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

	assign sts.ready = (state_q == W_IDLE);
	assign sts.done  = done_q;
	assign sts.root  = root_q;

endmodule

@@ design/union_find_path_halving.sv @@
`timescale 1ns / 1ps

// channel   signals                                          dir  handshake
// command   operation, first_element, second_element         in   start && !busy
// result    root_index                                       out  done, one cycle
//
// A find makes one walk to the root; a unite makes two walks, one from each
// element. Each hop costs one read of the parent and one read of the grandparent
// on the parent memory, which has one read and one write port, with the halving
// write made in the grandparent step. After reset a clearing pass writes every
// entry with its own index while busy stays high. Results cannot be stalled.

module union_find_path_halving
	import ufph_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              operation,
	input  logic [ELEM_W-1:0] first_element,
	input  logic [ELEM_W-1:0] second_element,
	output logic              done,
	output logic [ELEM_W-1:0] root_index
);

	typedef enum logic [1:0] {
		T_IDLE,
		T_WALK_B,
		T_WALK_A
	} tstate_t;

	tstate_t   state_q;
	logic      op_q;
	node_t     a_q;
	node_t     root_b_q;
	node_t     root_q;
	logic      done_q;
	logic      accept;
	walk_cmd_t cmd;
	walk_sts_t sts;

	assign busy   = (state_q != T_IDLE) || !sts.ready;
	assign accept = start && !busy;

	always_comb begin
		cmd.go        = 1'b0;
		cmd.link      = 1'b0;
		cmd.node      = a_q;
		cmd.link_addr = sts.root;
		cmd.link_data = root_b_q;
		unique case (state_q)
			T_IDLE: begin
				cmd.go   = accept;
				cmd.node = (operation == OP_UNITE) ? NODE_W'(second_element)
					: NODE_W'(first_element);
			end
			T_WALK_B: begin
				cmd.go = sts.done;
			end
			T_WALK_A: begin
				cmd.go   = sts.done && (op_q == OP_UNITE);
				cmd.link = 1'b1;
			end
			default: begin
				cmd.go = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= T_IDLE;
			op_q     <= 1'b0;
			a_q      <= '0;
			root_b_q <= '0;
			root_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						op_q    <= operation;
						a_q     <= NODE_W'(first_element);
						state_q <= (operation == OP_UNITE) ? T_WALK_B : T_WALK_A;
					end
				end
				T_WALK_B: begin
					if (sts.done) begin
						root_b_q <= sts.root;
						state_q  <= T_WALK_A;
					end
				end
				T_WALK_A: begin
					if (sts.done) begin
						done_q  <= 1'b1;
						root_q  <= (op_q == OP_UNITE) ? root_b_q : sts.root;
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	ufph_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts)
	);

	assign done       = done_q;
	assign root_index = root_q[ELEM_W-1:0];

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy low right after accepting a beat");

	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two result beats back to back");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a command in flight");

	a_walker_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_IDLE && sts.ready) |-> !sts.done)
		else $error("walk finished with no walk pending");

endmodule

@@ sim/union_find_checker.sv @@
`timescale 1ns / 1ps

module union_find_checker
	import ufph_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              operation,
	input  logic [ELEM_W-1:0] first_element,
	input  logic [ELEM_W-1:0] second_element,
	input  logic              done,
	input  logic [ELEM_W-1:0] root_index,
	output int                mismatches,
	output int                pending
);

	int unsigned shadow_parent [NUM_ELEMENTS];
	logic [ELEM_W-1:0] expected_roots [$];
	logic [ELEM_W-1:0] want_root;
	logic [ELEM_W-1:0] first_root;
	logic [ELEM_W-1:0] second_root;

	task automatic report_mismatch(input string what, input logic [ELEM_W-1:0] want,
			input logic [ELEM_W-1:0] got);
		$display("mismatch at %0t ns: %s, expected %0d, got %0d", $time, what, want, got);
		mismatches++;
	endtask

	// walk to the root, pointing each visited entry at its grandparent
	function automatic logic [ELEM_W-1:0] halving_find(input logic [ELEM_W-1:0] elem);
		int unsigned node;
		int unsigned up;
		int unsigned grand;
		int unsigned hops;
		node = elem;
		hops = 0;
		if (node >= NUM_ELEMENTS)
			return elem;
		while (hops < NUM_ELEMENTS) begin
			up = shadow_parent[node];
			if (up == node)
				break;
			grand = shadow_parent[up];
			shadow_parent[node] = grand;
			node = grand;
			hops++;
		end
		return ELEM_W'(node);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ELEMENTS; i++)
				shadow_parent[i] = i;
			expected_roots.delete();
			pending = 0;
			mismatches = 0;
		end else begin
			if (done) begin
				if (expected_roots.size() == 0) begin
					report_mismatch("root_index beat with no item outstanding", '0, root_index);
				end else begin
					want_root = expected_roots.pop_front();
					if (root_index !== want_root)
						report_mismatch("root_index", want_root, root_index);
				end
			end
			if (start && !busy) begin
				if (operation == OP_FIND) begin
					first_root = halving_find(first_element);
					expected_roots = {expected_roots, first_root};
				end else begin
					second_root = halving_find(second_element);
					first_root = halving_find(first_element);
					if (first_root < NUM_ELEMENTS)
						shadow_parent[first_root] = second_root;
					expected_roots = {expected_roots, second_root};
				end
			end
			pending = expected_roots.size();
		end
	end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import ufph_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              operation;
	logic [ELEM_W-1:0] first_element;
	logic [ELEM_W-1:0] second_element;
	logic              done;
	logic [ELEM_W-1:0] root_index;
	logic              accept_seen;
	int                mismatches;
	int                pending;
	int unsigned       window_base;

	union_find_path_halving u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.first_element  (first_element),
		.second_element (second_element),
		.done           (done),
		.root_index     (root_index)
	);

	union_find_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.first_element  (first_element),
		.second_element (second_element),
		.done           (done),
		.root_index     (root_index),
		.mismatches     (mismatches),
		.pending        (pending)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk)
		accept_seen <= start && !busy;

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// hold the beat until the block takes it
	task automatic issue_beat(input uf_op_t op, input logic [ELEM_W-1:0] a,
			input logic [ELEM_W-1:0] b);
		start <= 1'b1;
		operation <= op;
		first_element <= a;
		second_element <= b;
		do
			@(negedge clk);
		while (!accept_seen);
	endtask

	task automatic rest(input int cycles);
		start <= 1'b0;
		repeat (cycles)
			@(negedge clk);
	endtask

	task automatic settle();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic logic [ELEM_W-1:0] pick_element();
		if ($urandom_range(0, 9) < 7)
			return ELEM_W'(window_base + $urandom_range(0, 47));
		return ELEM_W'($urandom_range(0, 1023));
	endfunction

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_FIND;
		first_element = '0;
		second_element = '0;
		window_base = 0;
		repeat (7)
			@(negedge clk);
		arst_n = 1'b1;

		issue_beat(OP_FIND, 10'd0, 10'd0);
		issue_beat(OP_FIND, 10'd1023, 10'd1023);
		issue_beat(OP_UNITE, 10'd0, 10'd1023);
		issue_beat(OP_FIND, 10'd0, 10'd512);
		issue_beat(OP_UNITE, 10'd1023, 10'd0);
		issue_beat(OP_UNITE, 10'd0, 10'd1023);
		issue_beat(OP_UNITE, 10'd5, 10'd5);
		for (int k = 100; k < 111; k++)
			issue_beat(OP_UNITE, ELEM_W'(k), ELEM_W'(k + 1));
		issue_beat(OP_FIND, 10'd100, 10'd0);
		issue_beat(OP_FIND, 10'd100, 10'd1023);
		issue_beat(OP_UNITE, 10'd1023, 10'd101);
		issue_beat(OP_FIND, 10'd0, 10'd341);
		issue_beat(OP_FIND, 10'd682, 10'd682);
		rest(3);

		for (int n = 0; n < 450; n++) begin
			if (n % 150 == 0)
				window_base = $urandom_range(0, 1023 - 47);
			if (n == 225)
				settle();
			if ((n < 150 || n >= 300) && $urandom_range(0, 99) < 6)
				rest($urandom_range(1, 6));
			if ($urandom_range(0, 99) < 45)
				issue_beat(OP_UNITE, pick_element(), pick_element());
			else
				issue_beat(OP_FIND, pick_element(), ELEM_W'($urandom_range(0, 1023)));
		end

		settle();
		repeat (40)
			@(negedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
